// File: rtl/core/slkp_pkg.sv
// ----------------------------------------------------------------------------
// slkp_pkg: shared types and codes
// Operation codes, result status codes and hash constants for the string key
// linear probe table.
// ----------------------------------------------------------------------------
`default_nettype none

package slkp_pkg;

	localparam int unsigned HashBits = 32;
	localparam logic [HashBits-1:0] HashSeed = 32'd5381;
	localparam int unsigned HashShift = 5;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_SPARE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_NOT_FOUND  = 3'd1,
		STATUS_FULL       = 3'd2,
		STATUS_TOO_LONG   = 3'd3,
		STATUS_ZERO_VALUE = 3'd4
	} status_t;

	// handshake between the top level and the slot remainder unit
	typedef struct packed {
		logic start;
		logic done;
	} mod_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/slkp_item_if.sv
// ----------------------------------------------------------------------------
// slkp_item_if: key byte channel
// Valid/ready channel that carries one key byte beat with its operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface slkp_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  key_byte;
	logic        key_last;
	logic [31:0] store_value;

	modport source (output valid, output func, output key_byte, output key_last,
		output store_value, input ready);
	modport sink (input valid, input func, input key_byte, input key_last,
		input store_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/slkp_result_if.sv
// ----------------------------------------------------------------------------
// slkp_result_if: result channel
// Valid/ready channel that carries one status beat per finished operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface slkp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] found_value;

	modport source (output valid, output status, output found_value, input ready);
	modport sink (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/string_key_linear_probe_table.sv
// Flow: key bytes are taken one per cycle while the table is idle; after the last byte an
// operation finds the home slot through the remainder unit, reads and checks each probed
// slot, compares the key byte by byte against a candidate and copies it byte by byte on a fill.
// Operations: one at a time; the probe walk and the byte-wise compare
// through the slot and key RAM ports set the rate.
// Reset: a clearing pass empties every slot of the slot RAM; no beat is taken until it ends.
// ----------------------------------------------------------------------------
// string_key_linear_probe_table: open addressing key/value table
// Hashes a streamed byte key and inserts, deletes or looks it up with linear
// probing over slot and key RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module string_key_linear_probe_table #(
	parameter int unsigned TABLE_SIZE         = 256,
	parameter int unsigned KEY_BYTES          = 32,
	parameter int unsigned LOOKUP_PROBE_LIMIT = 128,
	parameter int unsigned VALUE_BITS         = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slkp_item_if.sink     item_in,
	slkp_result_if.source result_out
);

	localparam int unsigned SlotBits  = $clog2(TABLE_SIZE);
	localparam int unsigned LenBits   = $clog2(KEY_BYTES + 1);
	localparam int unsigned IdxBits   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int unsigned KeyAddrW  = $clog2(TABLE_SIZE * KEY_BYTES);
	localparam int unsigned MaxProbe  =
		(TABLE_SIZE > LOOKUP_PROBE_LIMIT) ? TABLE_SIZE : LOOKUP_PROBE_LIMIT;
	localparam int unsigned ProbeBits = $clog2(MaxProbe + 1);
	localparam int unsigned SlotWordW = LenBits + VALUE_BITS;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_CLEAR = 10'b0000000010,
		S_MOD   = 10'b0000000100,
		S_RD    = 10'b0000001000,
		S_CHK   = 10'b0000010000,
		S_CMP   = 10'b0000100000,
		S_CMPW  = 10'b0001000000,
		S_CPY   = 10'b0010000000,
		S_CPYW  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t                        state_q;
	logic [slkp_pkg::HashBits-1:0] hash_q;
	logic [LenBits-1:0]            klen_q;
	logic                          ovf_q;
	slkp_pkg::func_t               func_q;
	logic [VALUE_BITS-1:0]         v_q;
	logic [SlotBits-1:0]           slot_q;
	logic [SlotBits-1:0]           clr_q;
	logic [ProbeBits-1:0]          probe_q;
	logic [IdxBits-1:0]            idx_q;
	logic [VALUE_BITS-1:0]         val_q;
	slkp_pkg::status_t             st_q;
	logic [VALUE_BITS-1:0]         found_q;
	logic                          ov_q;
	slkp_pkg::status_t             ostat_q;
	logic [31:0]                   ofound_q;

	logic [slkp_pkg::HashBits-1:0] hash_nx;
	logic [VALUE_BITS+31:0]        v_ext;
	logic [VALUE_BITS-1:0]         v_in;
	logic [VALUE_BITS+31:0]        f_ext;
	logic                          take;
	logic                          buf_room;
	logic                          is_lookup;
	logic [ProbeBits-1:0]          probe_nx;
	logic [ProbeBits-1:0]          limit;
	logic [SlotBits-1:0]           slot_nx;
	logic [LenBits-1:0]            klen_m1;
	logic                          idx_last;
	logic [KeyAddrW-1:0]           key_addr;

	slkp_pkg::mod_ctl_t            mod_ctl;
	logic [SlotBits-1:0]           mod_rem;
	logic                          mod_start;

	logic                          vm_we;
	logic [SlotBits-1:0]           vm_waddr;
	logic [SlotWordW-1:0]          vm_wdata;
	logic                          vm_re;
	logic [SlotWordW-1:0]          vm_rdata;
	logic                          kb_we;
	logic                          kb_re;
	logic [7:0]                    kb_rdata;
	logic                          km_we;
	logic                          km_re;
	logic [7:0]                    km_rdata;

	// take the low value bits of the beat, zero extend past 32
	assign v_ext = {{VALUE_BITS{1'b0}}, item_in.store_value};
	assign v_in  = v_ext[VALUE_BITS-1:0];
	assign f_ext = {32'd0, found_q};

	// hash step: h * 33 xor byte
	assign hash_nx = ((hash_q << slkp_pkg::HashShift) + hash_q) ^
		{{(slkp_pkg::HashBits-8){1'b0}}, item_in.key_byte};

	assign item_in.ready = (state_q == S_IDLE);
	assign take          = item_in.valid && (state_q == S_IDLE);
	assign buf_room      = (klen_q < LenBits'(KEY_BYTES));
	assign mod_start     = take && item_in.key_last && !(ovf_q || !buf_room) &&
		!((slkp_pkg::func_t'(item_in.func) == slkp_pkg::FUNC_INSERT) && (v_in == '0));

	// probe advance
	assign is_lookup = (func_q != slkp_pkg::FUNC_INSERT) && (func_q != slkp_pkg::FUNC_DELETE);
	assign probe_nx  = probe_q + 1'b1;
	assign limit     = is_lookup ? ProbeBits'(LOOKUP_PROBE_LIMIT) : ProbeBits'(TABLE_SIZE);
	assign slot_nx   = (slot_q == SlotBits'(TABLE_SIZE - 1)) ? '0 : slot_q + 1'b1;
	assign klen_m1   = klen_q - 1'b1;
	assign idx_last  = (idx_q == klen_m1[IdxBits-1:0]);
	assign key_addr  = KeyAddrW'(slot_q) * KeyAddrW'(KEY_BYTES) + KeyAddrW'(idx_q);

	// memory controls
	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = slot_q;
		vm_wdata = {klen_q, v_q};
		case (state_q)
			S_CLEAR: begin
				vm_we    = 1'b1;
				vm_waddr = clr_q;
				vm_wdata = '0;
			end
			S_CPYW: begin
				vm_we = idx_last;
			end
			S_CMPW: begin
				vm_we = (kb_rdata == km_rdata) && idx_last && !is_lookup;
				if (func_q == slkp_pkg::FUNC_DELETE) begin
					vm_wdata = '0;
				end
			end
			default: begin
				vm_we = 1'b0;
			end
		endcase
	end

	assign vm_re = (state_q == S_RD);
	assign kb_we = take && buf_room;
	assign kb_re = (state_q == S_CMP) || (state_q == S_CPY);
	assign km_re = (state_q == S_CMP);
	assign km_we = (state_q == S_CPYW);

	slkp_mod_unit #(.DIVISOR(TABLE_SIZE)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_nx),
		.ctl       (mod_ctl),
		.remainder (mod_rem)
	);

	slkp_ram #(.WIDTH(SlotWordW), .DEPTH(TABLE_SIZE)) u_slot_ram (
		.clk   (clk),
		.we    (vm_we),
		.waddr (vm_waddr),
		.wdata (vm_wdata),
		.re    (vm_re),
		.raddr (slot_q),
		.rdata (vm_rdata)
	);

	slkp_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_kbuf_ram (
		.clk   (clk),
		.we    (kb_we),
		.waddr (klen_q[IdxBits-1:0]),
		.wdata (item_in.key_byte),
		.re    (kb_re),
		.raddr (idx_q),
		.rdata (kb_rdata)
	);

	slkp_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE * KEY_BYTES)) u_key_ram (
		.clk   (clk),
		.we    (km_we),
		.waddr (key_addr),
		.wdata (kb_rdata),
		.re    (km_re),
		.raddr (key_addr),
		.rdata (km_rdata)
	);

	// sequencer: intake, probe walk, compare, fill, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hash_q  <= slkp_pkg::HashSeed;
			klen_q  <= '0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (result_out.ready && (state_q != S_DONE)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SlotBits'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						hash_q <= hash_nx;
						if (buf_room) begin
							klen_q <= klen_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item_in.key_last) begin
							if (mod_start) begin
								state_q <= S_MOD;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_MOD: begin
					if (mod_ctl.done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (vm_rdata[VALUE_BITS-1:0] == '0) begin
						state_q <= (func_q == slkp_pkg::FUNC_INSERT) ? S_CPY : S_DONE;
					end else if (vm_rdata[SlotWordW-1:VALUE_BITS] == klen_q) begin
						state_q <= S_CMP;
					end else if (probe_nx == limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_CMP: begin
					state_q <= S_CMPW;
				end
				S_CMPW: begin
					if ((kb_rdata == km_rdata) && !idx_last) begin
						state_q <= S_CMP;
					end else if (kb_rdata == km_rdata) begin
						state_q <= S_DONE;
					end else if (probe_nx == limit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_CPY: begin
					state_q <= S_CPYW;
				end
				S_CPYW: begin
					state_q <= idx_last ? S_DONE : S_CPY;
				end
				S_DONE: begin
					if (!ov_q || result_out.ready) begin
						ov_q    <= 1'b1;
						hash_q  <= slkp_pkg::HashSeed;
						klen_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take && item_in.key_last) begin
					func_q  <= slkp_pkg::func_t'(item_in.func);
					v_q     <= v_in;
					found_q <= '0;
					if (ovf_q || !buf_room) begin
						st_q <= slkp_pkg::STATUS_TOO_LONG;
					end else if ((slkp_pkg::func_t'(item_in.func) == slkp_pkg::FUNC_INSERT)
						&& (v_in == '0)) begin
						st_q <= slkp_pkg::STATUS_ZERO_VALUE;
					end else begin
						st_q <= slkp_pkg::STATUS_NOT_FOUND;
					end
				end
			end
			S_MOD: begin
				slot_q  <= mod_rem;
				probe_q <= '0;
			end
			S_CHK: begin
				val_q  <= vm_rdata[VALUE_BITS-1:0];
				idx_q  <= '0;
				if (vm_rdata[VALUE_BITS-1:0] == '0) begin
					if (func_q == slkp_pkg::FUNC_INSERT) begin
						st_q <= slkp_pkg::STATUS_OK;
					end
				end else if (vm_rdata[SlotWordW-1:VALUE_BITS] != klen_q) begin
					probe_q <= probe_nx;
					slot_q  <= slot_nx;
					if ((probe_nx == limit) && (func_q == slkp_pkg::FUNC_INSERT)) begin
						st_q <= slkp_pkg::STATUS_FULL;
					end
				end
			end
			S_CMPW: begin
				if (kb_rdata == km_rdata) begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						st_q <= slkp_pkg::STATUS_OK;
						if (is_lookup) begin
							found_q <= val_q;
						end
					end
				end else begin
					probe_q <= probe_nx;
					slot_q  <= slot_nx;
					if ((probe_nx == limit) && (func_q == slkp_pkg::FUNC_INSERT)) begin
						st_q <= slkp_pkg::STATUS_FULL;
					end
				end
			end
			S_CPYW: begin
				idx_q <= idx_q + 1'b1;
			end
			S_DONE: begin
				if (!ov_q || result_out.ready) begin
					ostat_q  <= st_q;
					ofound_q <= f_ext[31:0];
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign result_out.valid       = ov_q;
	assign result_out.status      = ostat_q;
	assign result_out.found_value = ofound_q;

endmodule

`default_nettype wire

// File: rtl/core/slkp_ram.sv
// ----------------------------------------------------------------------------
// slkp_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slkp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AddrBits-1:0]    waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AddrBits-1:0]    raddr,
	output logic      [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/slkp_mod_unit.sv
// ----------------------------------------------------------------------------
// slkp_mod_unit: hash to home slot
// Remainder of the 32-bit hash by the table size through a rounded-up reciprocal
// multiply; the hash, the product and the remainder are registered in turn, and done marks the remainder ready.
// ----------------------------------------------------------------------------
`default_nettype none

module slkp_mod_unit #(
	parameter int unsigned DIVISOR = 256,
	localparam int unsigned SlotBits = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [slkp_pkg::HashBits-1:0]        dividend,
	output slkp_pkg::mod_ctl_t                        ctl,
	output logic      [SlotBits-1:0]                  remainder
);

	localparam int unsigned ShiftBits = $clog2(DIVISOR);
	localparam int unsigned ProdBits  = 2 * slkp_pkg::HashBits + 1;
	localparam int unsigned QuoBits   = slkp_pkg::HashBits + 1;
	// ceil(2^(32+L) / DIVISOR) lies in [2^32, 2^33); keep the part above 2^32
	localparam longint unsigned RecipFull =
		((64'd1 << (slkp_pkg::HashBits + ShiftBits)) + 64'(DIVISOR) - 64'd1) /
		64'(DIVISOR);
	localparam logic [31:0] RecipLo = 32'(RecipFull - (64'd1 << slkp_pkg::HashBits));

	logic [slkp_pkg::HashBits-1:0] num_q;
	logic                          vld_s1;
	logic                          vld_s2;
	logic [ProdBits-1:0]           prod_s2;
	logic                          done_q;
	logic [SlotBits-1:0]           rem_q;
	logic [ProdBits-1:0]           prod_nx;
	logic [QuoBits-1:0]            quo;
	logic [63:0]                   back;

	// hash times reciprocal: h * 2^32 + h * low part
	assign prod_nx = {1'b0, num_q, 32'd0} + {1'b0, 64'(num_q) * 64'(RecipLo)};
	assign quo     = QuoBits'(prod_s2 >> (slkp_pkg::HashBits + ShiftBits));
	assign back    = 64'(num_q) - 64'(quo) * 64'(DIVISOR);

	// advance the stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// datapath: hold the hash, multiply, then subtract quotient times divisor
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end
		if (vld_s1) begin
			prod_s2 <= prod_nx;
		end
		if (vld_s2) begin
			rem_q <= back[SlotBits-1:0];
		end
	end

	assign ctl.start  = vld_s1 || vld_s2;
	assign ctl.done   = done_q;
	assign remainder  = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/slkp_checker.sv
// ----------------------------------------------------------------------------
// slkp_checker: port level checks
// Watches the result channel of the table and flags illegal beats.
// ----------------------------------------------------------------------------
`default_nettype none

module slkp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  res_status,
	input wire logic [31:0] res_found
);

	// hold a result beat until it is taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before ready");

	// status codes stay within the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status <= 3'(slkp_pkg::STATUS_ZERO_VALUE)))
		else $error("undefined status code");

	// a found value only comes with an ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_found != 32'd0) |-> (res_status == 3'(slkp_pkg::STATUS_OK)))
		else $error("found value without ok status");

endmodule

bind string_key_linear_probe_table slkp_checker u_slkp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result_out.valid),
	.res_ready  (result_out.ready),
	.res_status (result_out.status),
	.res_found  (result_out.found_value)
);

`default_nettype wire
